// ===== rtl/core/fdhs_pkg.sv =====
// ----------------------------------------------------------------------------
// fdhs_pkg
// shared types and constants for the fan drive hysteresis / slew block
// ----------------------------------------------------------------------------
`default_nettype none

package fdhs_pkg;

  localparam int unsigned PctW   = 7;
  localparam int unsigned BurnW  = 3;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;
  localparam int unsigned InTdW  = 16;
  localparam int unsigned OutTdW = 8;

  // burn state codes
  localparam logic [BurnW-1:0] FIRE_IDLE   = 3'd0;
  localparam logic [BurnW-1:0] FIRE_RAMP   = 3'd1;
  localparam logic [BurnW-1:0] FIRE_HOLD   = 3'd2;
  localparam logic [BurnW-1:0] FIRE_BOOST  = 3'd3;
  localparam logic [BurnW-1:0] FIRE_SAFETY = 3'd4;

  // register byte addresses
  localparam logic [AddrW-1:0] REG_CLAMP_MIN = 4'h0;
  localparam logic [AddrW-1:0] REG_CLAMP_MAX = 4'h4;
  localparam logic [AddrW-1:0] REG_ALWAYS_ON = 4'h8;

  localparam logic [PctW-1:0] CLAMP_MIN_RST = 7'd20;
  localparam logic [PctW-1:0] CLAMP_MAX_RST = 7'd100;
  localparam logic [PctW-1:0] BOOST_DRIVE   = 7'd100;
  localparam logic [PctW-1:0] REARM_GAP     = 7'd10;
  localparam logic [PctW-1:0] SLEW_STEP     = 7'd3;

  typedef struct packed {
    logic [PctW-1:0] clamp_min;
    logic [PctW-1:0] clamp_max;
    logic            always_on;
  } cfg_t;

  typedef struct packed {
    logic             fan_en;
    logic [BurnW-1:0] prev_burn;
    logic [PctW-1:0]  last_drive;
  } ctl_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/fdhs_calc.sv =====
// ----------------------------------------------------------------------------
// fdhs_calc
// per-word fan drive decision: state tracking, clamp, hysteresis and slew
// ----------------------------------------------------------------------------
`default_nettype none

module fdhs_calc (
  input  wire fdhs_pkg::cfg_t                 cfg_i,
  input  wire fdhs_pkg::ctl_state_t           state_i,
  input  wire logic [fdhs_pkg::PctW-1:0]      demand_i,
  input  wire logic [fdhs_pkg::BurnW-1:0]     burn_i,
  output fdhs_pkg::ctl_state_t                state_o,
  output logic [fdhs_pkg::PctW-1:0]           fan_o
);

  logic                        en_chg;
  logic [fdhs_pkg::PctW-1:0]   target;
  logic [fdhs_pkg::PctW:0]     rearm_lvl;
  logic signed [fdhs_pkg::PctW+1:0] diff;
  logic signed [fdhs_pkg::PctW+1:0] step;
  logic [fdhs_pkg::PctW+1:0]   slewed;

  // clamp: min first, max last
  always_comb begin
    target = demand_i;
    if (target < cfg_i.clamp_min) target = cfg_i.clamp_min;
    if (target > cfg_i.clamp_max) target = cfg_i.clamp_max;
  end

  // slew limit toward target
  always_comb begin
    diff = $signed({2'b00, target}) - $signed({2'b00, state_i.last_drive});
    step = diff;
    if (diff > $signed({2'b00, fdhs_pkg::SLEW_STEP})) begin
      step = $signed({2'b00, fdhs_pkg::SLEW_STEP});
    end else if (diff < -$signed({2'b00, fdhs_pkg::SLEW_STEP})) begin
      step = -$signed({2'b00, fdhs_pkg::SLEW_STEP});
    end
    slewed = $unsigned($signed({2'b00, state_i.last_drive}) + step);
  end

  assign rearm_lvl = {1'b0, cfg_i.clamp_min} + {1'b0, fdhs_pkg::REARM_GAP};

  always_comb begin
    // burn state transition tracking
    en_chg = state_i.fan_en;
    if (burn_i != state_i.prev_burn) begin
      if (state_i.prev_burn == fdhs_pkg::FIRE_HOLD && burn_i == fdhs_pkg::FIRE_RAMP) begin
        en_chg = 1'b1;
      end
      if (burn_i == fdhs_pkg::FIRE_BOOST || burn_i == fdhs_pkg::FIRE_IDLE ||
          burn_i == fdhs_pkg::FIRE_SAFETY) begin
        en_chg = 1'b0;
      end
    end

    state_o.prev_burn  = burn_i;
    state_o.last_drive = state_i.last_drive;
    state_o.fan_en     = en_chg;
    fan_o              = '0;

    if (burn_i == fdhs_pkg::FIRE_SAFETY) begin
      state_o.fan_en = 1'b0;
    end else if (burn_i == fdhs_pkg::FIRE_BOOST) begin
      state_o.fan_en = 1'b1;
      fan_o          = fdhs_pkg::BOOST_DRIVE;
    end else if (cfg_i.always_on) begin
      state_o.fan_en     = 1'b1;
      state_o.last_drive = slewed[fdhs_pkg::PctW-1:0];
      fan_o              = slewed[fdhs_pkg::PctW-1:0];
    end else if (demand_i < cfg_i.clamp_min) begin
      state_o.fan_en = 1'b0;
    end else begin
      // hysteresis: rearm only well above the off threshold
      if ({1'b0, demand_i} >= rearm_lvl) state_o.fan_en = 1'b1;
      if (state_o.fan_en) begin
        state_o.last_drive = slewed[fdhs_pkg::PctW-1:0];
        fan_o              = slewed[fdhs_pkg::PctW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fan_drive_hysteresis_slew_top.sv =====
// ----------------------------------------------------------------------------
// fan_drive_hysteresis_slew_top
// fan drive with burn-state tracking, off hysteresis and +/-3 slew limit
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  s_axis    in   tvalid/tready    tdata: demand[6:0], burn_state[9:7]
//  m_axis    out  tvalid/tready    tdata: fan_percent[6:0]
//  apb cfg   in   psel/penable     clamp_min @0x0, clamp_max @0x4, always_on @0x8
//
//  one word per cycle sustained while m_axis accepts: an input register feeds the
//  decision logic, whose result lands in the output register
//  control state (enable, previous burn, last drive) updates as a word moves
//  from the input register into the output register
//  a stall on m_axis holds both stages; each stage refills as it empties
//  reset clears valids, control state and config registers to their defaults
//
`default_nettype none

module fan_drive_hysteresis_slew_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input words
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [fdhs_pkg::InTdW-1:0]    s_axis_tdata,   // demand[6:0], burn_state[9:7]
  // result words
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [fdhs_pkg::OutTdW-1:0]        m_axis_tdata,   // fan_percent[6:0]
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fdhs_pkg::AddrW-1:0]    paddr,
  input  wire logic [fdhs_pkg::DataW-1:0]    pwdata,
  output logic [fdhs_pkg::DataW-1:0]         prdata,
  output logic                               pready
);

  fdhs_pkg::cfg_t       cfg_q;
  fdhs_pkg::ctl_state_t st_q, st_d;

  logic                         in_vld_q;
  logic [fdhs_pkg::PctW-1:0]    demand_q;
  logic [fdhs_pkg::BurnW-1:0]   burn_q;
  logic                         out_vld_q;
  logic [fdhs_pkg::PctW-1:0]    fan_q, fan_d;
  logic                         adv;
  logic                         cfg_wr;

  // ---------------------------------------------------------------- apb
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clamp_min <= fdhs_pkg::CLAMP_MIN_RST;
      cfg_q.clamp_max <= fdhs_pkg::CLAMP_MAX_RST;
      cfg_q.always_on <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr)
        fdhs_pkg::REG_CLAMP_MIN: cfg_q.clamp_min <= pwdata[fdhs_pkg::PctW-1:0];
        fdhs_pkg::REG_CLAMP_MAX: cfg_q.clamp_max <= pwdata[fdhs_pkg::PctW-1:0];
        fdhs_pkg::REG_ALWAYS_ON: cfg_q.always_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      fdhs_pkg::REG_CLAMP_MIN: prdata = {{(fdhs_pkg::DataW-fdhs_pkg::PctW){1'b0}}, cfg_q.clamp_min};
      fdhs_pkg::REG_CLAMP_MAX: prdata = {{(fdhs_pkg::DataW-fdhs_pkg::PctW){1'b0}}, cfg_q.clamp_max};
      fdhs_pkg::REG_ALWAYS_ON: prdata = {{(fdhs_pkg::DataW-1){1'b0}}, cfg_q.always_on};
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- pipeline
  // the decision stage moves whenever the output register is free or draining
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      demand_q <= s_axis_tdata[fdhs_pkg::PctW-1:0];
      burn_q   <= s_axis_tdata[fdhs_pkg::PctW +: fdhs_pkg::BurnW];
    end
  end

  fdhs_calc u_calc (
    .cfg_i    (cfg_q),
    .state_i  (st_q),
    .demand_i (demand_q),
    .burn_i   (burn_q),
    .state_o  (st_d),
    .fan_o    (fan_d)
  );

  // control state commits when a word leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.fan_en     <= 1'b0;
      st_q.prev_burn  <= fdhs_pkg::FIRE_IDLE;
      st_q.last_drive <= '0;
      out_vld_q       <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_vld_q) fan_q <= fan_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(fdhs_pkg::OutTdW-fdhs_pkg::PctW){1'b0}}, fan_q};

  // ---------------------------------------------------------------- checks
  // safety always drives the fan off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_vld_q && burn_q == fdhs_pkg::FIRE_SAFETY) |=> (fan_q == '0))
    else $error("safety word did not give zero drive");

  // boost always drives full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_vld_q && burn_q == fdhs_pkg::FIRE_BOOST) |=> (fan_q == fdhs_pkg::BOOST_DRIVE))
    else $error("boost word did not give full drive");

  // slewed drive never moves more than the step limit per word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      ({1'b0, st_q.last_drive} <= {1'b0, $past(st_q.last_drive)} + {1'b0, fdhs_pkg::SLEW_STEP}) &&
      ({1'b0, st_q.last_drive} + {1'b0, fdhs_pkg::SLEW_STEP} >= {1'b0, $past(st_q.last_drive)}))
    else $error("drive moved more than slew step");

  // control state only changes when a word is consumed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && in_vld_q) |=> $stable(st_q))
    else $error("control state changed without a word");

endmodule

`default_nettype wire
